### hdl/stack_machine_execute_unit_defines.svh
// Assertion macros for the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMX_ASSERT_NEXT(label, clk, rst_n, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);
`else
`define SMX_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SMX_ASSERT_NEXT(label, clk, rst_n, cond, result, msg)
`endif
`endif

### hdl/smx_pkg.sv
//------------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine execute unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package smx_pkg;
    localparam int DEF_STACK_DEPTH      = 256;
    localparam int DEF_MAX_FRAMES       = 16;
    localparam int DEF_LOCALS_PER_FRAME = 16;
    localparam int DEF_CODE_ADDR_BITS   = 16;

    localparam logic [4:0] OP_PUSH  = 5'd0;
    localparam logic [4:0] OP_ADD   = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_MUL   = 5'd3;
    localparam logic [4:0] OP_JMP   = 5'd4;
    localparam logic [4:0] OP_JZ    = 5'd5;
    localparam logic [4:0] OP_JNZ   = 5'd6;
    localparam logic [4:0] OP_JEQ   = 5'd7;
    localparam logic [4:0] OP_JGE   = 5'd12;
    localparam logic [4:0] OP_CEQ   = 5'd13;
    localparam logic [4:0] OP_CGE   = 5'd18;
    localparam logic [4:0] OP_CALL  = 5'd19;
    localparam logic [4:0] OP_STLOC = 5'd20;
    localparam logic [4:0] OP_LOAD  = 5'd21;
    localparam logic [4:0] OP_RET   = 5'd22;
    localparam logic [4:0] OP_EMIT  = 5'd23;
    localparam logic [4:0] OP_HALT  = 5'd24;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_TOO_DEEP  = 3'd3;
    localparam logic [2:0] ST_NO_FRAME  = 3'd4;
    localparam logic [2:0] ST_BAD_LOCAL = 3'd5;

    // Result transaction fields.
    typedef struct packed {
        logic [2:0]  status;
        logic        halted;
        logic [31:0] print_value;
        logic        print_valid;
        logic [31:0] top_before;
        logic [15:0] next_ip;
    } smx_result_t;

    // cond: 0 eq,1 ne,2 lt,3 gt,4 le,5 ge on (l OP r), signed.
    function automatic logic smx_cond(input logic [2:0] sel, input logic [31:0] l,
                                      input logic [31:0] r);
        logic lt;
        logic eq;
        lt = $signed(l) < $signed(r);
        eq = l == r;
        case (sel)
            3'd0:    smx_cond = eq;
            3'd1:    smx_cond = !eq;
            3'd2:    smx_cond = lt;
            3'd3:    smx_cond = !lt && !eq;
            3'd4:    smx_cond = lt || eq;
            default: smx_cond = !lt;
        endcase
    endfunction
endpackage

### hdl/stack_machine_execute_unit.sv
//------------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one decoded stack-machine instruction per input transaction.
//------------------------------------------------------------------------------
// Usage: s_axis carries one decoded instruction per transaction and m_axis
// returns exactly one result transaction for each, in order.
// Every instruction completes in the cycle it is accepted; its result sits in
// a two-entry output buffer from the next cycle on, and one instruction is
// taken per cycle with no bubbles for any mix while the buffer has space.
// The top two stack values live in registers and the rest of the operand
// stack in a memory with registered reads. The third and fourth entries are
// read ahead every cycle from the next depth, with a write-first bypass, so a
// pop of one or two values finds them waiting. A load lands in the top in the
// next cycle and is taken straight from the local memory read register.
// Return addresses are read ahead from the next frame depth the same way.
// Reset empties the stack and returns to the base frame; the memories are
// not cleared. When the receiver stalls, the buffer takes two results and
// s_axis_tready stays low while both entries are held.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_defines.svh"
module stack_machine_execute_unit
#(
    parameter int STACK_DEPTH      = smx_pkg::DEF_STACK_DEPTH,
    parameter int MAX_FRAMES       = smx_pkg::DEF_MAX_FRAMES,
    parameter int LOCALS_PER_FRAME = smx_pkg::DEF_LOCALS_PER_FRAME,
    parameter int CODE_ADDR_BITS   = smx_pkg::DEF_CODE_ADDR_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[4:0], instr_addr[20:5], operand_a[52:21], arg_count[60:53],
    // local_count[68:61], zero fill to 72 bits
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_ip[15:0], top_before[47:16], print_valid[48], print_value[80:49],
    // halted[81], status[84:82], zero fill to 88 bits
    output logic [87:0] m_axis_tdata
);
    import smx_pkg::*;

    localparam int SW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int FW  = $clog2(MAX_FRAMES) > 0 ? $clog2(MAX_FRAMES) : 1;
    localparam int LW  = $clog2(LOCALS_PER_FRAME + 1);
    localparam int LIW = $clog2(LOCALS_PER_FRAME) > 0 ? $clog2(LOCALS_PER_FRAME) : 1;
    localparam int LMD = MAX_FRAMES * LOCALS_PER_FRAME;
    localparam int LAW = $clog2(LMD) > 0 ? $clog2(LMD) : 1;
    localparam logic [SW-1:0] S_FULL = SW'(STACK_DEPTH);
    localparam logic [LW-1:0] L_FULL = LW'(LOCALS_PER_FRAME);
    localparam logic [CODE_ADDR_BITS-1:0] A1 = CODE_ADDR_BITS'(1);
    localparam logic [CODE_ADDR_BITS-1:0] A2 = CODE_ADDR_BITS'(2);
    localparam logic [CODE_ADDR_BITS-1:0] A4 = CODE_ADDR_BITS'(4);

    logic [4:0]  op;
    logic [15:0] iaddr;
    logic [31:0] opa;
    logic [7:0]  argc, locc;
    assign op    = s_axis_tdata[4:0];
    assign iaddr = s_axis_tdata[20:5];
    assign opa   = s_axis_tdata[52:21];
    assign argc  = s_axis_tdata[60:53];
    assign locc  = s_axis_tdata[68:61];

    // Memories.
    logic [31:0]               stk_mem [STACK_DEPTH];
    logic [31:0]               loc_mem [LMD];
    logic [CODE_ADDR_BITS-1:0] ra_mem  [MAX_FRAMES];
    logic [31:0]               rd3_reg, rd4_reg, loc_rd_reg;
    logic [CODE_ADDR_BITS-1:0] ra_rd_reg;

    logic [SW-1:0]  n_reg, n_next;
    logic [31:0]    t0_reg, t0_next, t1_reg, t1_next;
    logic           ld_pend_reg, ld_pend_next;    // top value is in loc_rd_reg
    logic [FW-1:0]  fd_reg, fd_next;
    logic [LW-1:0]  fsz_reg [MAX_FRAMES];

    logic        acc, space;
    logic [31:0] t0, t1, alu;
    logic [CODE_ADDR_BITS-1:0] addr_m, opa_m, nxt, ra_wdata;
    logic [2:0]  st;
    logic        pv, hlt;
    logic        push, ld_rd, pop1, pop2, use_alu, st_wr, fr_push, fr_pop;
    logic        ra_we;
    logic [FW-1:0] ra_raddr;
    logic [LW-1:0] new_sz;
    logic [8:0]  sum_sz;
    logic        idx_ok;
    logic [LAW-1:0] slot;
    logic        stk_wr;
    logic [SAW-1:0] stk_waddr, rd3_addr, rd4_addr;
    logic [31:0] stk_wdata;
    smx_result_t res;

    assign acc           = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = space;

    // The top may still be waiting in the local memory read register.
    assign t0 = ld_pend_reg ? loc_rd_reg : t0_reg;
    assign t1 = t1_reg;

    assign addr_m = CODE_ADDR_BITS'(iaddr);
    assign opa_m  = CODE_ADDR_BITS'(opa);
    assign idx_ok = !opa[31] && (opa < 32'(fsz_reg[fd_reg]));
    assign slot   = LAW'(fd_reg) * LAW'(LOCALS_PER_FRAME) + LAW'(opa[LIW-1:0]);
    assign sum_sz = {1'b0, argc} + {1'b0, locc};
    assign new_sz = (sum_sz > 9'(LOCALS_PER_FRAME)) ? L_FULL : LW'(sum_sz);

    always_comb
    begin
        case (op)
            OP_ADD:  alu = t1 + t0;
            OP_SUB:  alu = t1 - t0;
            OP_MUL:  alu = t1 * t0;
            default: alu = {31'd0, smx_cond(3'(op - OP_CEQ), t1, t0)};
        endcase
    end

    // Instruction decode and checks.
    always_comb
    begin
        nxt     = addr_m + A1;
        st      = ST_OK;
        pv      = 1'b0;
        hlt     = 1'b0;
        push    = 1'b0;
        ld_rd   = 1'b0;
        pop1    = 1'b0;
        pop2    = 1'b0;
        use_alu = 1'b0;
        st_wr   = 1'b0;
        fr_push = 1'b0;
        fr_pop  = 1'b0;
        if (op == OP_PUSH)
        begin
            if (n_reg >= S_FULL)
                st = ST_OVERFLOW;
            else
            begin
                push = 1'b1;
                nxt  = addr_m + A2;
            end
        end
        else if (op == OP_ADD || op == OP_SUB || op == OP_MUL ||
                 (op >= OP_CEQ && op <= OP_CGE))
        begin
            if (n_reg < SW'(2))
                st = ST_UNDERFLOW;
            else
            begin
                pop1    = 1'b1;
                use_alu = 1'b1;
            end
        end
        else if (op == OP_JMP)
        begin
            nxt = opa_m;
        end
        else if (op == OP_JZ || op == OP_JNZ)
        begin
            if (n_reg < SW'(1))
                st = ST_UNDERFLOW;
            else
            begin
                pop1 = 1'b1;
                nxt  = ((t0 == 32'd0) == (op == OP_JZ)) ? opa_m : addr_m + A2;
            end
        end
        else if (op >= OP_JEQ && op <= OP_JGE)
        begin
            if (n_reg < SW'(2))
                st = ST_UNDERFLOW;
            else
            begin
                pop2 = 1'b1;
                nxt  = smx_cond(3'(op - OP_JEQ), t1, t0) ? opa_m : addr_m + A2;
            end
        end
        else if (op == OP_CALL)
        begin
            if (32'(fd_reg) + 32'd1 >= 32'(MAX_FRAMES))
                st = ST_TOO_DEEP;
            else
            begin
                fr_push = 1'b1;
                nxt     = opa_m;
            end
        end
        else if (op == OP_STLOC)
        begin
            if (!idx_ok)
                st = ST_BAD_LOCAL;
            else if (n_reg < SW'(1))
                st = ST_UNDERFLOW;
            else
            begin
                st_wr = 1'b1;
                pop1  = 1'b1;
                nxt   = addr_m + A2;
            end
        end
        else if (op == OP_LOAD)
        begin
            if (!idx_ok)
                st = ST_BAD_LOCAL;
            else if (n_reg >= S_FULL)
                st = ST_OVERFLOW;
            else
            begin
                ld_rd = 1'b1;
                push  = 1'b1;
                nxt   = addr_m + A2;
            end
        end
        else if (op == OP_RET)
        begin
            if (fd_reg == FW'(0))
                st = ST_NO_FRAME;
            else
            begin
                fr_pop = 1'b1;
                nxt    = ra_rd_reg;
            end
        end
        else if (op == OP_EMIT)
        begin
            if (n_reg < SW'(1))
                st = ST_UNDERFLOW;
            else
            begin
                pv   = 1'b1;
                pop1 = 1'b1;
            end
        end
        else if (op == OP_HALT)
        begin
            hlt = 1'b1;
            nxt = addr_m;
        end
        if (st != ST_OK)
            nxt = addr_m;
    end

    // State update of the depth, the cached top two entries and the frame.
    always_comb
    begin
        n_next       = n_reg;
        t0_next      = t0;
        t1_next      = t1;
        ld_pend_next = ld_pend_reg;
        fd_next      = fd_reg;
        stk_wr       = 1'b0;
        stk_waddr    = SAW'(n_reg - SW'(2));
        stk_wdata    = t1;
        if (acc)
        begin
            ld_pend_next = 1'b0;
            if (push)
            begin
                n_next       = n_reg + SW'(1);
                t1_next      = t0;
                t0_next      = opa;
                ld_pend_next = ld_rd;
                // The old second value spills to entry n-2.
                stk_wr       = n_reg >= SW'(2);
            end
            else if (pop1)
            begin
                n_next  = n_reg - SW'(1);
                t0_next = use_alu ? alu : t1;
                t1_next = rd3_reg;
            end
            else if (pop2)
            begin
                n_next  = n_reg - SW'(2);
                t0_next = rd3_reg;
                t1_next = rd4_reg;
            end
            if (fr_push)
                fd_next = fd_reg + FW'(1);
            else if (fr_pop)
                fd_next = fd_reg - FW'(1);
        end
    end

    // Read-ahead addresses follow the depth that the next cycle will see.
    assign rd3_addr = SAW'(n_next - SW'(3));
    assign rd4_addr = SAW'(n_next - SW'(4));
    assign ra_raddr = fd_next - FW'(1);
    assign ra_we    = acc && fr_push;
    assign ra_wdata = addr_m + A4;

    always_ff @(posedge clk)
    begin
        if (stk_wr)
            stk_mem[stk_waddr] <= stk_wdata;
        rd3_reg <= (stk_wr && stk_waddr == rd3_addr) ? stk_wdata : stk_mem[rd3_addr];
        rd4_reg <= (stk_wr && stk_waddr == rd4_addr) ? stk_wdata : stk_mem[rd4_addr];
        if (acc && st_wr)
            loc_mem[slot] <= t0;
        if (acc && ld_rd)
            loc_rd_reg <= loc_mem[slot];
        if (ra_we)
            ra_mem[fd_reg] <= ra_wdata;
        ra_rd_reg <= (ra_we && fd_reg == ra_raddr) ? ra_wdata : ra_mem[ra_raddr];
        t0_reg <= t0_next;
        t1_reg <= t1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= '0;
            fd_reg      <= '0;
            ld_pend_reg <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
                fsz_reg[i] <= L_FULL;
        end
        else
        begin
            n_reg       <= n_next;
            fd_reg      <= fd_next;
            ld_pend_reg <= ld_pend_next;
            if (acc && fr_push)
                fsz_reg[fd_reg + FW'(1)] <= new_sz;
        end
    end

    always_comb
    begin
        res.next_ip     = 16'(nxt);
        res.top_before  = (n_reg == '0) ? 32'hFFFF_FFFF : t0;
        res.print_valid = pv;
        res.print_value = pv ? t0 : 32'd0;
        res.halted      = hlt;
        res.status      = st;
    end

    smx_result_t m_res;
    smx_out_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .in_data   (res),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_res)
    );

    assign m_axis_tdata = {3'd0, m_res.status, m_res.halted, m_res.print_value,
                           m_res.print_valid, m_res.top_before, m_res.next_ip};

    `SMX_ASSERT_NEXT(a_push_grows, clk, rst_n, acc && push, n_reg == $past(n_reg) + SW'(1),
        "push did not grow the stack")
    `SMX_ASSERT_NEXT(a_err_keeps, clk, rst_n, acc && (st != ST_OK),
        n_reg == $past(n_reg) && fd_reg == $past(fd_reg), "error changed state")
    `SMX_ASSERT_IMPL(a_depth_bound, clk, rst_n, n_reg <= S_FULL, "stack depth out of range")
endmodule

### hdl/smx_out_skid.sv
//------------------------------------------------------------------------------
// smx_out_skid
// Two-entry output buffer that decouples the execute stage from the receiver.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module smx_out_skid
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  smx_pkg::smx_result_t in_data,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output smx_pkg::smx_result_t out_data
);
    import smx_pkg::*;

    smx_result_t buf_reg [2];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = buf_reg[rp_reg];
    // Space comes from the count alone, so the receiver's ready never reaches
    // the input ready combinationally.
    assign space     = cnt_reg != 2'd2;

    always_comb
    begin
        wp_next  = wp_reg ^ in_valid;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, in_valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            buf_reg[wp_reg] <= in_data;
        end
    end
endmodule
